@@ rtl/core/dppd_pkg.sv @@
package dppd_pkg;

  // Packet geometry and timer width
  localparam int MAX_PACKET_BYTES = 6;
  localparam int TIMER_BITS       = 16;
  localparam int SHOWN_BYTES      = 6;

  localparam int BIDX_W = $clog2(MAX_PACKET_BYTES + 2);
  localparam int WIDX_W = $clog2(MAX_PACKET_BYTES);

  // Decoder thresholds
  localparam int PREAMBLE_MIN_ONES = 10;
  localparam int DATA_BITS         = 8;
  localparam int MIN_PACKET_BYTES  = 3;

  // Field widths
  localparam int TIMER_W  = 16;
  localparam int COUNT_W  = 16;
  localparam int THRESH_W = 15;
  localparam int LEN_W    = 3;
  localparam int RUN_W    = 5;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_USE_MODEM_DATA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DC_LEVEL       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_THRESHOLD = 2'd2;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd180;

  // Operation codes
  localparam logic OP_EDGE      = 1'b0;
  localparam logic OP_SET_COUNT = 1'b1;

  typedef struct packed {
    logic                use_modem_data;
    logic                dc_level;
    logic [THRESH_W-1:0] long_pulse_threshold;
  } cfg_t;

  typedef struct packed {
    logic               operation;
    logic               pin_level;
    logic [TIMER_W-1:0] timer_value;
    logic [COUNT_W-1:0] count_value;
  } item_t;

  typedef struct packed {
    logic                           drive_level;
    logic [COUNT_W-1:0]             transition_count;
    logic                           packet_done;
    logic [LEN_W-1:0]               packet_length;
    logic [SHOWN_BYTES-1:0][7:0]    packet_bytes;
  } result_t;

endpackage

@@ rtl/core/dcc_pulse_packet_decoder.sv @@
// DCC pulse packet decoder.
// Input channel (in_valid/in_ready): one transaction per pin edge event, or a
// command that loads the transition count. Edges are timed by timer_value;
// a falling edge yields one DCC bit that steps the packet state machine.
// Output channel (out_valid/out_ready): exactly one result transaction per
// input transaction, in order: drive level, transition count, a done flag
// for a freshly latched packet with a good check byte, and the held packet.
// Configuration channel (cfg_valid/cfg_ready): always ready; write only while
// the block is idle.
// An accepted item waits in the input register, then the single-pass step
// logic loads the result register once that register is free.
// Throughput is one transaction per cycle while the receiver takes results,
// set by the state feedback loop through the step logic.
// When the receiver stalls, the result register holds and the input register
// still takes one more transaction; in_ready falls once both are full.
// Reset clears both stages, the packet state and held packet, and restores
// the configuration defaults (follow input, dc level 1, threshold 180).
module dcc_pulse_packet_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            operation,
  input  logic                            pin_level,
  input  logic [dppd_pkg::TIMER_W-1:0]    timer_value,
  input  logic [dppd_pkg::COUNT_W-1:0]    count_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            drive_level,
  output logic [dppd_pkg::COUNT_W-1:0]    transition_count,
  output logic                            packet_done,
  output logic [dppd_pkg::LEN_W-1:0]      packet_length,
  output logic [7:0]                      packet_byte0,
  output logic [7:0]                      packet_byte1,
  output logic [7:0]                      packet_byte2,
  output logic [7:0]                      packet_byte3,
  output logic [7:0]                      packet_byte4,
  output logic [7:0]                      packet_byte5,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dppd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dppd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dppd_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_full;
  logic    advance;
  result_t step_res;
  result_t out_res;

  assign cfg_ready = 1'b1;

  dppd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Move the held transaction on whenever the result register is free
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item.operation   <= operation;
      in_item.pin_level   <= pin_level;
      in_item.timer_value <= timer_value;
      in_item.count_value <= count_value;
    end
  end

  dppd_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (in_item),
    .cfg  (cfg),
    .res  (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_res <= '0;
    end else if (advance) begin
      out_res <= step_res;
    end
  end

  assign drive_level      = out_res.drive_level;
  assign transition_count = out_res.transition_count;
  assign packet_done      = out_res.packet_done;
  assign packet_length    = out_res.packet_length;
  assign packet_byte0     = out_res.packet_bytes[0];
  assign packet_byte1     = out_res.packet_bytes[1];
  assign packet_byte2     = out_res.packet_bytes[2];
  assign packet_byte3     = out_res.packet_bytes[3];
  assign packet_byte4     = out_res.packet_bytes[4];
  assign packet_byte5     = out_res.packet_bytes[5];

endmodule

@@ rtl/core/dppd_cfg.sv @@
module dppd_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [dppd_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [dppd_pkg::CFG_DATA_W-1:0] wr_data,
  output dppd_pkg::cfg_t                  cfg
);
  import dppd_pkg::*;

  // Hold the register file; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.use_modem_data       <= 1'b1;
      cfg.dc_level             <= 1'b1;
      cfg.long_pulse_threshold <= THRESH_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_USE_MODEM_DATA: cfg.use_modem_data       <= wr_data[0];
        CFG_DC_LEVEL:       cfg.dc_level             <= wr_data[0];
        CFG_LONG_THRESHOLD: cfg.long_pulse_threshold <= wr_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/dppd_core.sv @@
module dppd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  dppd_pkg::item_t   item,
  input  dppd_pkg::cfg_t    cfg,
  output dppd_pkg::result_t res
);
  import dppd_pkg::*;

  typedef enum logic [1:0] {
    PH_PREAMBLE = 2'd0,
    PH_START    = 2'd1,
    PH_DATA     = 2'd2,
    PH_END      = 2'd3
  } phase_t;

  phase_t                phase, phase_next;
  logic [RUN_W-1:0]      bit_run, bit_run_next;
  logic [7:0]            shift_byte, shift_byte_next;
  logic [BIDX_W-1:0]     byte_index, byte_index_next;
  logic [7:0]            work_bytes [MAX_PACKET_BYTES];
  logic [7:0]            work_bytes_next [MAX_PACKET_BYTES];
  logic [TIMER_BITS-1:0] edge_start_time, edge_start_time_next;
  logic [COUNT_W-1:0]    edge_count, edge_count_next;
  logic [7:0]            held_bytes [MAX_PACKET_BYTES];
  logic [7:0]            held_bytes_next [MAX_PACKET_BYTES];
  logic [BIDX_W-1:0]     held_length, held_length_next;
  logic                  drive_reg, drive_reg_next;
  logic                  done;

  logic [TIMER_BITS-1:0] now;
  logic [TIMER_BITS-1:0] diff;
  logic                  bit_val;
  logic [RUN_W-1:0]      run_inc;
  logic [7:0]            shifted;
  logic [7:0]            check_acc;
  logic                  check_ok;

  // Measure the pulse and slice it into a bit
  always_comb begin
    now     = TIMER_BITS'(item.timer_value);
    diff    = now - edge_start_time;
    bit_val = !(!diff[TIMER_BITS-1] &&
                (33'(diff) > 33'(cfg.long_pulse_threshold)));
    run_inc = (bit_run == {RUN_W{1'b1}}) ? bit_run : bit_run + 1'b1;
    shifted = {shift_byte[6:0], bit_val};
  end

  // XOR of every present byte is zero exactly when the check byte matches
  always_comb begin
    check_acc = '0;
    for (int k = 0; k < MAX_PACKET_BYTES; k++) begin
      if (BIDX_W'(k) < byte_index) check_acc = check_acc ^ work_bytes[k];
    end
    check_ok = (check_acc == 8'd0);
  end

  // Advance the packet state machine by one event
  always_comb begin
    phase_next           = phase;
    bit_run_next         = bit_run;
    shift_byte_next      = shift_byte;
    byte_index_next      = byte_index;
    work_bytes_next      = work_bytes;
    edge_start_time_next = edge_start_time;
    edge_count_next      = edge_count;
    held_bytes_next      = held_bytes;
    held_length_next     = held_length;
    drive_reg_next       = drive_reg;
    done                 = 1'b0;

    if (item.operation == OP_SET_COUNT) begin
      edge_count_next = item.count_value;
    end else if (item.pin_level) begin
      edge_start_time_next = now;
      drive_reg_next       = cfg.use_modem_data ? 1'b1 : cfg.dc_level;
    end else begin
      drive_reg_next  = cfg.use_modem_data ? 1'b0 : cfg.dc_level;
      edge_count_next = edge_count + 1'b1;
      bit_run_next    = run_inc;
      case (phase)
        PH_PREAMBLE: begin
          if (bit_val) begin
            if (run_inc > RUN_W'(PREAMBLE_MIN_ONES)) begin
              phase_next      = PH_START;
              edge_count_next = '0;
              for (int k = 0; k < MAX_PACKET_BYTES; k++) work_bytes_next[k] = 8'd0;
            end
          end else begin
            bit_run_next = '0;
          end
        end
        PH_START: begin
          if (!bit_val) begin
            bit_run_next    = '0;
            byte_index_next = '0;
            phase_next      = PH_DATA;
            edge_count_next = '0;
            shift_byte_next = 8'd0;
          end
        end
        PH_DATA: begin
          shift_byte_next = shifted;
          if (run_inc == RUN_W'(DATA_BITS)) begin
            if (byte_index < BIDX_W'(MAX_PACKET_BYTES))
              work_bytes_next[byte_index[WIDX_W-1:0]] = shifted;
            if (byte_index <= BIDX_W'(MAX_PACKET_BYTES))
              byte_index_next = byte_index + 1'b1;
            shift_byte_next = 8'd0;
            phase_next      = PH_END;
            edge_count_next = '0;
          end
        end
        PH_END: begin
          edge_count_next = '0;
          bit_run_next    = '0;
          if (bit_val) begin
            phase_next = PH_PREAMBLE;
            if (byte_index >= BIDX_W'(MIN_PACKET_BYTES) &&
                byte_index <= BIDX_W'(MAX_PACKET_BYTES) && check_ok) begin
              for (int k = 0; k < MAX_PACKET_BYTES; k++)
                held_bytes_next[k] = (BIDX_W'(k) < byte_index) ? work_bytes[k] : 8'd0;
              held_length_next = byte_index;
              done             = 1'b1;
            end
          end else begin
            phase_next = PH_DATA;
          end
        end
        default: phase_next = PH_PREAMBLE;
      endcase
    end
  end

  // Commit state when the transaction advances
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_PREAMBLE;
      bit_run         <= '0;
      shift_byte      <= 8'd0;
      byte_index      <= '0;
      edge_start_time <= '0;
      edge_count      <= '0;
      held_length     <= '0;
      drive_reg       <= 1'b1;
      for (int k = 0; k < MAX_PACKET_BYTES; k++) begin
        work_bytes[k] <= 8'd0;
        held_bytes[k] <= 8'd0;
      end
    end else if (step) begin
      phase           <= phase_next;
      bit_run         <= bit_run_next;
      shift_byte      <= shift_byte_next;
      byte_index      <= byte_index_next;
      edge_start_time <= edge_start_time_next;
      edge_count      <= edge_count_next;
      held_length     <= held_length_next;
      drive_reg       <= drive_reg_next;
      work_bytes      <= work_bytes_next;
      held_bytes      <= held_bytes_next;
    end
  end

  // Present the post-event view for the result register
  always_comb begin
    res.drive_level      = drive_reg_next;
    res.transition_count = edge_count_next;
    res.packet_done      = done;
    res.packet_length    = LEN_W'(held_length_next);
    for (int k = 0; k < SHOWN_BYTES; k++) begin
      if (k < MAX_PACKET_BYTES) res.packet_bytes[k] = held_bytes_next[k];
      else res.packet_bytes[k] = 8'd0;
    end
  end

endmodule

@@ rtl/core/dppd_checker.sv @@
module dppd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         drive_level,
  input logic [dppd_pkg::COUNT_W-1:0] transition_count,
  input logic                         packet_done,
  input logic [dppd_pkg::LEN_W-1:0]   packet_length,
  input logic [7:0]                   packet_byte3,
  input logic [7:0]                   packet_byte4,
  input logic [7:0]                   packet_byte5
);
  import dppd_pkg::*;

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(transition_count) &&
      $stable(drive_level) && $stable(packet_done) && $stable(packet_length))
    else $error("stalled result changed");

  // No result straight out of reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !out_valid)
    else $error("result present after reset");

  // A completed packet has a legal length
  a_done_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_done |->
      packet_length >= LEN_W'(MIN_PACKET_BYTES) &&
      packet_length <= LEN_W'(MAX_PACKET_BYTES))
    else $error("packet completed with bad length");

  // Bytes beyond a short packet read as zero
  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_length < LEN_W'(4) |->
      packet_byte3 == 8'd0 && packet_byte4 == 8'd0 && packet_byte5 == 8'd0)
    else $error("absent packet byte not zero");

endmodule

bind dcc_pulse_packet_decoder dppd_checker u_dppd_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .drive_level      (drive_level),
  .transition_count (transition_count),
  .packet_done      (packet_done),
  .packet_length    (packet_length),
  .packet_byte3     (packet_byte3),
  .packet_byte4     (packet_byte4),
  .packet_byte5     (packet_byte5)
);
